// File: hw/rtl/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg: shared types and step functions
// Stage records and the per-stage square-root and division steps.
// ----------------------------------------------------------------------------
package qrs_pkg;

	localparam int SQ_STEPS = 32;  // result bits of the root
	localparam int DV_STEPS = 34;  // quotient bits
	localparam int NUM_W    = 34;  // numerator magnitude width
	localparam int DEN_W    = 16;  // divisor magnitude width

	localparam logic [1:0] ST_TWO  = 2'd0;
	localparam logic [1:0] ST_DBL  = 2'd1;
	localparam logic [1:0] ST_NONE = 2'd2;
	localparam logic [1:0] ST_AZ   = 2'd3;

	localparam logic signed [31:0] ROOT_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] ROOT_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic signed [15:0] a;
		logic signed [15:0] b;
		logic        [31:0] bb;
		logic signed [31:0] ac;
	} prod_t;

	typedef struct packed {
		logic        [1:0]  status;
		logic signed [33:0] disc;
		logic signed [31:0] nb;
		logic signed [15:0] a;
		logic        [63:0] x;
		logic        [63:0] res;
	} sq_t;

	typedef struct packed {
		logic        [1:0]       status;
		logic signed [33:0]      disc;
		logic                    neg_p;
		logic                    neg_m;
		logic        [NUM_W-1:0] num_p;
		logic        [NUM_W-1:0] num_m;
		logic        [DEN_W-1:0] rem_p;
		logic        [DEN_W-1:0] rem_m;
		logic        [NUM_W-1:0] quo_p;
		logic        [NUM_W-1:0] quo_m;
		logic        [DEN_W-1:0] den;
	} dv_t;

	// one iteration of the digit-by-digit root, bit weight 4^(31-k)
	function automatic sq_t sq_step(input sq_t s, input int k);
		sq_t         r;
		logic [63:0] bitw;
		logic [63:0] trial;
		r     = s;
		bitw  = 64'd1 << (62 - 2 * k);
		trial = s.res + bitw;
		if (s.x >= trial) begin
			r.x   = s.x - trial;
			r.res = (s.res >> 1) + bitw;
		end else begin
			r.res = s.res >> 1;
		end
		return r;
	endfunction

	// one restoring step for one dividend
	function automatic void dv_one(
		input  logic [NUM_W-1:0] num, input logic [DEN_W-1:0] rem,
		input  logic [NUM_W-1:0] quo, input logic [DEN_W-1:0] den,
		output logic [NUM_W-1:0] num_o, output logic [DEN_W-1:0] rem_o,
		output logic [NUM_W-1:0] quo_o);
		logic [DEN_W:0] part;
		logic           ge;
		part  = {rem, num[NUM_W-1]};
		ge    = part >= {1'b0, den};
		num_o = {num[NUM_W-2:0], 1'b0};
		rem_o = ge ? DEN_W'(part - {1'b0, den}) : part[DEN_W-1:0];
		quo_o = {quo[NUM_W-2:0], ge};
	endfunction

	function automatic dv_t dv_step(input dv_t s);
		dv_t r;
		r = s;
		dv_one(s.num_p, s.rem_p, s.quo_p, s.den, r.num_p, r.rem_p, r.quo_p);
		dv_one(s.num_m, s.rem_m, s.quo_m, s.den, r.num_m, r.rem_m, r.quo_m);
		return r;
	endfunction

	// apply sign and clip to 32 bits
	function automatic logic [32:0] clip(input logic neg, input logic [NUM_W-1:0] q);
		logic signed [NUM_W:0] v;
		logic                  sat;
		logic signed [31:0]    o;
		v = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
		if (v > $signed((NUM_W+1)'(ROOT_MAX))) begin
			o = ROOT_MAX; sat = 1'b1;
		end else if (v < (NUM_W+1)'(ROOT_MIN)) begin
			o = ROOT_MIN; sat = 1'b1;
		end else begin
			o = v[31:0]; sat = 1'b0;
		end
		return {sat, o};
	endfunction

endpackage

// File: hw/rtl/qrs_if.sv
// ----------------------------------------------------------------------------
// qrs_if: coefficient and root stream interfaces
// Valid/ready channels; a beat moves when both are high.
// ----------------------------------------------------------------------------
interface qrs_coef_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] a_coeff;
	logic signed [15:0] b_coeff;
	logic signed [15:0] c_coeff;
	modport source (output valid, a_coeff, b_coeff, c_coeff, input ready);
	modport sink   (input valid, a_coeff, b_coeff, c_coeff, output ready);
endinterface

interface qrs_root_if;
	logic               valid;
	logic               ready;
	logic        [1:0]  status;
	logic signed [31:0] root_plus;
	logic signed [31:0] root_minus;
	logic signed [33:0] discriminant;
	logic               saturated;
	modport source (output valid, status, root_plus, root_minus, discriminant, saturated,
		input ready);
	modport sink   (input valid, status, root_plus, root_minus, discriminant, saturated,
		output ready);
endinterface

// File: hw/rtl/quadratic_root_solver.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver: real roots of a*x^2 + b*x + c
// Pipelined discriminant, square root and two dividers, one beat per cycle while roots.ready stays high.
// ----------------------------------------------------------------------------
// Usage
//   coef  : sink channel, one beat holds a, b, c in signed Q8.8.
//   roots : source channel, one beat per coefficient beat, in order:
//           status, both roots (Q16.16, truncated, clipped), the exact
//           discriminant (Q16.16) and a clip flag.
//   cfg_we/cfg_wdata : double-root threshold, write only while idle.
// Timing
//   The pipe holds one multiply stage, one classify stage, 32 root
//   stages (one result bit each), one numerator stage, 34 divide stages
//   (one quotient bit each) and the output register.
//   Throughput is one beat per cycle while roots.ready stays high.
// Stall
//   The whole pipe advances together; when the output beat waits, every
//   stage holds and coef.ready drops. Nothing is dropped or repeated.
// Reset
//   arst_n clears all valid bits and the threshold to zero.
// ----------------------------------------------------------------------------
module quadratic_root_solver (
	input  logic        clk,
	input  logic        arst_n,
	qrs_coef_if.sink    coef,
	qrs_root_if.source  roots,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);
	import qrs_pkg::*;

	logic [15:0] thr_q;
	logic        adv;

	// stage 1: products
	prod_t prod_s1;
	logic  v_s1;
	// classify result feeds the root chain
	sq_t   sq_s  [0:SQ_STEPS];
	logic  sqv_s [0:SQ_STEPS];
	dv_t   dv_s  [0:DV_STEPS];
	logic  dvv_s [0:DV_STEPS];
	logic  out_valid_q;

	assign adv        = !out_valid_q || roots.ready;
	assign coef.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= '0;
		end else if (cfg_we) begin
			thr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= coef.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prod_s1.a  <= coef.a_coeff;
			prod_s1.b  <= coef.b_coeff;
			prod_s1.bb <= 32'(coef.b_coeff * coef.b_coeff);
			prod_s1.ac <= coef.a_coeff * coef.c_coeff;
		end
	end

	// classify: D = b*b - 4ac, pick status, build radicand D << 30 for two distinct roots
	logic signed [33:0] disc_c;
	sq_t                cls_c;
	always_comb begin
		disc_c       = $signed({2'b00, prod_s1.bb}) - ($signed(34'(prod_s1.ac)) <<< 2);
		cls_c.disc   = disc_c;
		cls_c.a      = prod_s1.a;
		cls_c.nb     = -($signed(32'(prod_s1.b)) <<< 15);
		cls_c.res    = '0;
		cls_c.x      = '0;
		if (prod_s1.a == '0) begin
			cls_c.status = ST_AZ;
		end else if (disc_c < 0) begin
			cls_c.status = ST_NONE;
		end else if (disc_c <= $signed({18'b0, thr_q})) begin
			cls_c.status = ST_DBL;
		end else begin
			cls_c.status = ST_TWO;
			cls_c.x      = {disc_c[33:0], 30'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sqv_s[0] <= 1'b0;
		end else if (adv) begin
			sqv_s[0] <= v_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (adv) sq_s[0] <= cls_c;
	end

	// square root, one result bit per stage
	for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sqv_s[k+1] <= 1'b0;
			end else if (adv) begin
				sqv_s[k+1] <= sqv_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) sq_s[k+1] <= sq_step(sq_s[k], k);
		end
	end

	// numerators -b*2^15 +/- S, split into sign and magnitude
	sq_t                sqe;
	logic signed [34:0] np_c, nm_c;
	dv_t                num_c;
	always_comb begin
		sqe          = sq_s[SQ_STEPS];
		np_c         = 35'(sqe.nb) + $signed({2'b00, sqe.res[32:0]});
		nm_c         = 35'(sqe.nb) - $signed({2'b00, sqe.res[32:0]});
		num_c.status = sqe.status;
		num_c.disc   = sqe.disc;
		num_c.neg_p  = np_c[34] ^ sqe.a[15];
		num_c.neg_m  = nm_c[34] ^ sqe.a[15];
		num_c.num_p  = np_c[34] ? NUM_W'(-np_c) : NUM_W'(np_c);
		num_c.num_m  = nm_c[34] ? NUM_W'(-nm_c) : NUM_W'(nm_c);
		num_c.den    = sqe.a[15] ? DEN_W'(-sqe.a) : DEN_W'(sqe.a);
		num_c.rem_p  = '0;
		num_c.rem_m  = '0;
		num_c.quo_p  = '0;
		num_c.quo_m  = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvv_s[0] <= 1'b0;
		end else if (adv) begin
			dvv_s[0] <= sqv_s[SQ_STEPS];
		end
	end
	always_ff @(posedge clk) begin
		if (adv) dv_s[0] <= num_c;
	end

	// two restoring dividers side by side, one quotient bit per stage
	for (genvar k = 0; k < DV_STEPS; k++) begin : g_dv
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dvv_s[k+1] <= 1'b0;
			end else if (adv) begin
				dvv_s[k+1] <= dvv_s[k];
			end
		end
		always_ff @(posedge clk) begin
			if (adv) dv_s[k+1] <= dv_step(dv_s[k]);
		end
	end

	// sign, clip, zero roots for the no-root and error cases
	dv_t         dve;
	logic [32:0] cp_c, cm_c;
	always_comb begin
		dve  = dv_s[DV_STEPS];
		cp_c = clip(dve.neg_p, dve.quo_p);
		cm_c = clip(dve.neg_m, dve.quo_m);
		if (dve.status == ST_AZ || dve.status == ST_NONE) begin
			cp_c = '0;
			cm_c = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= dvv_s[DV_STEPS];
		end
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			roots.status       <= dve.status;
			roots.discriminant <= dve.disc;
			roots.root_plus    <= cp_c[31:0];
			roots.root_minus   <= cm_c[31:0];
			roots.saturated    <= cp_c[32] | cm_c[32];
		end
	end

	assign roots.valid = out_valid_q;

endmodule

// File: hw/rtl/qrs_checker.sv
// ----------------------------------------------------------------------------
// qrs_checker: port-level checks for the root solver
// Watches both channels, checks stall behaviour and flags result beats that contradict their status.
// ----------------------------------------------------------------------------
module qrs_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic        [1:0]  status,
	input logic signed [31:0] root_plus,
	input logic signed [31:0] root_minus,
	input logic signed [33:0] discriminant,
	input logic               saturated
);
	import qrs_pkg::*;

	// stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(root_plus) && $stable(status))
		else $error("result beat changed while stalled");

	// input side follows the output stall
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("coef ready does not track output stall");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_AZ || status == ST_NONE)
		|-> root_plus == 0 && root_minus == 0 && !saturated)
		else $error("roots not cleared for no-root status");

	a_neg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_NONE |-> discriminant[33])
		else $error("no-root status with non-negative discriminant");

	a_dbl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_DBL |-> root_plus == root_minus && !discriminant[33])
		else $error("double root mismatch");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (coef.ready),
	.out_valid    (roots.valid),
	.out_ready    (roots.ready),
	.status       (roots.status),
	.root_plus    (roots.root_plus),
	.root_minus   (roots.root_minus),
	.discriminant (roots.discriminant),
	.saturated    (roots.saturated)
);
